// ===== rtl/pva_pkg.sv =====
// pva_pkg: shared types and constants of the polyphonic voice allocator
// no dependencies
`default_nettype none
package pva_pkg;

  localparam int REG_POS = 8;  // positions that have register bits

  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_ALL_OFF  = 3'd2;
  localparam logic [2:0] OP_ARP_ON   = 3'd3;
  localparam logic [2:0] OP_ARP_OFF  = 3'd4;

  localparam logic [1:0] MODE_RR     = 2'd0;
  localparam logic [1:0] MODE_UNISON = 2'd1;

  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_SPLIT     = 3'd1;
  localparam logic [2:0] CFG_MELODIC   = 3'd2;
  localparam logic [2:0] CFG_GROUP     = 3'd3;
  localparam logic [2:0] CFG_GRP_EN    = 3'd4;
  localparam logic [2:0] CFG_TIER      = 3'd5;
  localparam logic [2:0] CFG_CHAN_EN   = 3'd6;
  localparam logic [2:0] CFG_CHAN_IDS  = 3'd7;

  localparam logic CMD_OFF = 1'b0;
  localparam logic CMD_ON  = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] note;
    logic [6:0] velocity;
  } req_t;

  typedef struct packed {
    logic       command;
    logic [3:0] channel_id;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } rsp_t;

  // state of one voice position
  typedef struct packed {
    logic        busy;
    logic [6:0]  note;
    logic [31:0] age;
  } voice_t;

endpackage
`default_nettype wire

// ===== rtl/pva_if.sv =====
// pva_if: request and response channel interfaces
// depends on pva_pkg
`default_nettype none
interface pva_req_if import pva_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pva_rsp_if import pva_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/pva_cell.sv =====
// pva_cell: one voice position of the rotating state ring
// depends on pva_pkg
`default_nettype none
module pva_cell import pva_pkg::*; (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    shift_i,
  input  voice_t voice_i,
  output voice_t voice_o
);
  voice_t voice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else if (shift_i) begin
      voice_q <= voice_i;
    end
  end

  assign voice_o = voice_q;
endmodule
`default_nettype wire

// ===== rtl/polyphonic_voice_allocator.sv =====
// polyphonic_voice_allocator: maps note events onto chip channel positions
// depends on pva_pkg, pva_if, pva_cell
//
// usage: requests (opcode, note, velocity) arrive on req; each produces zero
// or more chip commands on rsp, the final one flagged with last. registers
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
// them only while idle, as the block itself does not enforce it.
// the voice state sits in a ring of NUM_POSITIONS cells that rotates one
// position per cycle past a single head, where the controller inspects and
// rewrites it, while a pass runs and the output does not stall.
// a request is taken only when the previous one is fully done.
// passes per request: note off, all off, unison note on: one pass;
// round robin or split note on: two passes (search then trigger);
// arp on with a release: one more pass. the ring also holds while a note-off
// goes out ahead of a note-on on the same position, and a closing step ends
// each request. commands go through a one-entry holding stage and an output
// register, so a stalled receiver freezes the ring without loss.
// reset frees every position, zeroes stamps and the arp note, and loads
// register defaults; no clearing pass is needed.
`default_nettype none
module polyphonic_voice_allocator import pva_pkg::*; #(
  parameter int NUM_POSITIONS = 8,
  parameter int NUM_GROUPS    = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pva_req_if.sink    req,
  pva_rsp_if.source  rsp,
  input  wire        cfg_we_i,
  input  wire [2:0]  cfg_idx_i,
  input  wire [31:0] cfg_data_i
);
  localparam int IW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_POSITIONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_OFF, ST_ALL, ST_TRIG, ST_FLUSH
  } state_e;

  // configuration
  logic [1:0]  mode_q;
  logic [7:0]  split_q, melodic_q, grp_en_q, tier_q, chan_en_q;
  logic [23:0] group_q;
  logic [31:0] chan_ids_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RR;
      split_q    <= 8'd60;
      melodic_q  <= 8'hff;
      group_q    <= '0;
      grp_en_q   <= 8'd1;
      tier_q     <= '0;
      chan_en_q  <= 8'hff;
      chan_ids_q <= 32'h7654_3210;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     mode_q     <= cfg_data_i[1:0];
        CFG_SPLIT:    split_q    <= cfg_data_i[7:0];
        CFG_MELODIC:  melodic_q  <= cfg_data_i[7:0];
        CFG_GROUP:    group_q    <= cfg_data_i[23:0];
        CFG_GRP_EN:   grp_en_q   <= cfg_data_i[7:0];
        CFG_TIER:     tier_q     <= cfg_data_i[7:0];
        CFG_CHAN_EN:  chan_en_q  <= cfg_data_i[7:0];
        CFG_CHAN_IDS: chan_ids_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e         state_q;
  logic [IW-1:0]  idx_q;
  logic           sub_q;
  logic [6:0]     note_q, vel_q, off_note_q;
  logic           then_on_q;
  logic [31:0]    age_q;
  logic           arp_valid_q;
  logic [6:0]     arp_note_q;
  logic           mt_v_q, fr_v_q, od_v_q;
  logic [IW-1:0]  mt_i_q, fr_i_q, od_i_q;
  logic [31:0]    od_age_q;
  logic           pend_valid_q, out_valid_q;
  rsp_t           pend_q, out_q;

  // ring of cells
  voice_t ring_q [NUM_POSITIONS];
  voice_t head, tail;
  logic   advance;

  for (genvar i = 0; i < NUM_POSITIONS; i++) begin : g_cell
    voice_t cin;
    if (i == NUM_POSITIONS - 1) begin : g_tail
      assign cin = tail;
    end else begin : g_mid
      assign cin = ring_q[i+1];
    end
    pva_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (advance),
      .voice_i (cin),
      .voice_o (ring_q[i])
    );
  end
  assign head = ring_q[0];

  // per-position attributes of the head position
  logic [3:0] pos4;
  logic [2:0] pl, grp;
  logic       in_reg, usable, tier, cen;
  logic [3:0] chan;
  logic [7:0] ge_eff;

  always_comb begin
    pos4   = 4'(idx_q);
    pl     = pos4[2:0];
    in_reg = (32'(pos4) < REG_POS);
    grp    = group_q[pl*3 +: 3];
    ge_eff = grp_en_q | 8'd1;
    usable = in_reg && melodic_q[pl] && (32'(grp) < NUM_GROUPS) && ge_eff[grp];
    tier   = in_reg && tier_q[pl];
    cen    = in_reg && chan_en_q[pl];
    chan   = in_reg ? chan_ids_q[pl*4 +: 4] : 4'd0;
  end

  logic want_tier, elig, p_v, target, last_pass;
  logic [IW-1:0] p_i;

  assign want_tier = ({1'b0, note_q} >= split_q);
  assign elig      = usable && ((mode_q == MODE_RR) || (tier == want_tier));
  assign last_pass = (idx_q == LAST_IDX);

  always_comb begin
    p_v = 1'b1;
    p_i = od_i_q;
    if (mt_v_q) p_i = mt_i_q;
    else if (fr_v_q) p_i = fr_i_q;
    else if (!od_v_q) p_v = 1'b0;
  end

  assign target = (mode_q == MODE_UNISON) ? (usable && cen) : (p_v && idx_q == p_i);

  // head step: what to emit and what to write back
  logic emit, step, progress, out_free, sub_d;
  rsp_t emit_rsp;

  assign out_free = !out_valid_q || rsp.ready;

  always_comb begin
    emit     = 1'b0;
    step     = 1'b0;
    sub_d    = sub_q;
    tail     = head;
    emit_rsp = '0;
    emit_rsp.channel_id = chan;
    unique case (state_q)
      ST_SCAN: step = 1'b1;
      ST_OFF: begin
        step = 1'b1;
        if (head.busy && head.note == off_note_q) begin
          emit      = 1'b1;
          tail.busy = 1'b0;
        end
      end
      ST_ALL: begin
        step      = 1'b1;
        emit      = 1'b1;
        tail.busy = 1'b0;
      end
      ST_TRIG: begin
        if (target && head.busy && !sub_q) begin
          emit  = 1'b1;
          sub_d = 1'b1;
        end else if (target) begin
          emit                  = 1'b1;
          step                  = 1'b1;
          sub_d                 = 1'b0;
          emit_rsp.command      = CMD_ON;
          emit_rsp.out_note     = note_q;
          emit_rsp.out_velocity = vel_q;
          tail.busy             = 1'b1;
          tail.note             = note_q;
          tail.age              = age_q + 32'd1;
        end else begin
          step = 1'b1;
        end
      end
      default: ;
    endcase
    progress = !emit || !pend_valid_q || out_free;
  end

  assign advance = step && progress;

  logic acc;
  assign acc       = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);

  state_e on_state;
  assign on_state = (mode_q == MODE_UNISON) ? ST_TRIG : ST_SCAN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      sub_q        <= 1'b0;
      then_on_q    <= 1'b0;
      age_q        <= '0;
      arp_valid_q  <= 1'b0;
      arp_note_q   <= '0;
      mt_v_q       <= 1'b0;
      fr_v_q       <= 1'b0;
      od_v_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      note_q       <= '0;
      vel_q        <= '0;
      off_note_q   <= '0;
      mt_i_q       <= '0;
      fr_i_q       <= '0;
      od_i_q       <= '0;
      od_age_q     <= '0;
      pend_q       <= '0;
      out_q        <= '0;
    end else begin
      // cleared only when no new command moves into the output register
      if (out_valid_q && rsp.ready && !(emit && progress && pend_valid_q) &&
          !(state_q == ST_FLUSH && pend_valid_q)) begin
        out_valid_q <= 1'b0;
      end

      if (emit && progress) begin
        sub_q <= sub_d;
        if (pend_valid_q) begin
          out_q       <= pend_q;
          out_valid_q <= 1'b1;
        end
        pend_q       <= emit_rsp;
        pend_valid_q <= 1'b1;
      end

      if (state_q == ST_TRIG && advance && target) age_q <= age_q + 32'd1;

      // search for the round robin / split target
      if (state_q == ST_SCAN && elig) begin
        if (mode_q == MODE_RR && head.busy && head.note == note_q && !mt_v_q) begin
          mt_v_q <= 1'b1;
          mt_i_q <= idx_q;
        end
        if (!head.busy && !fr_v_q) begin
          fr_v_q <= 1'b1;
          fr_i_q <= idx_q;
        end
        if (!od_v_q || head.age < od_age_q) begin
          od_v_q   <= 1'b1;
          od_i_q   <= idx_q;
          od_age_q <= head.age;
        end
      end

      if (advance) begin
        idx_q <= last_pass ? '0 : idx_q + IW'(1);
        if (last_pass) begin
          unique case (state_q)
            ST_SCAN: state_q <= ST_TRIG;
            ST_OFF:  state_q <= then_on_q ? on_state : ST_FLUSH;
            default: state_q <= ST_FLUSH;
          endcase
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            note_q    <= req.payload.note;
            vel_q     <= req.payload.velocity;
            then_on_q <= 1'b0;
            sub_q     <= 1'b0;
            mt_v_q    <= 1'b0;
            fr_v_q    <= 1'b0;
            od_v_q    <= 1'b0;
            priority case (req.payload.opcode)
              OP_NOTE_ON: state_q <= on_state;
              OP_NOTE_OFF: begin
                off_note_q <= req.payload.note;
                state_q    <= ST_OFF;
              end
              OP_ALL_OFF: state_q <= ST_ALL;
              OP_ARP_ON: begin
                arp_valid_q <= 1'b1;
                arp_note_q  <= req.payload.note;
                off_note_q  <= arp_note_q;
                if (arp_valid_q && arp_note_q != req.payload.note) begin
                  then_on_q <= 1'b1;
                  state_q   <= ST_OFF;
                end else begin
                  state_q <= on_state;
                end
              end
              OP_ARP_OFF: begin
                arp_valid_q <= 1'b0;
                off_note_q  <= arp_note_q;
                state_q     <= arp_valid_q ? ST_OFF : ST_FLUSH;
              end
              default: state_q <= ST_FLUSH;
            endcase
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            // last is the low bit of the packed command
            out_q        <= {pend_q[$bits(rsp_t)-1:1], 1'b1};
            out_valid_q  <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid   = out_valid_q;
  assign rsp.payload = out_q;

  // ring is home whenever no request is in flight
  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> idx_q == '0 && !pend_valid_q)
    else $error("ring not aligned or result pending while idle");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q != ST_IDLE)
    else $error("accepted request did not start");

  a_age_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    age_q != $past(age_q) |-> $past(state_q) == ST_TRIG)
    else $error("stamp counter moved outside trigger pass");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp.ready && pend_valid_q |=> !$past(advance && emit) ||
      $past(!emit))
    else $error("emitted into a full holding stage");

endmodule
`default_nettype wire
